// ===== rtl/core/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants of the piecewise-linear calibrator
// Holds the fixed widths and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

  localparam int unsigned NumRegs  = 8;   // calibration point registers
  localparam int unsigned IdxW     = 3;   // index into the point registers
  localparam int unsigned CfgIdxW  = 4;   // register index on the config port
  localparam int unsigned CfgW     = 32;  // widest register
  localparam int unsigned DataW    = 16;  // reading and output value width
  localparam int unsigned DivCntW  = 4;   // counts the quotient bits

  localparam logic [DataW-1:0] OutOfRangeValue = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new reading, restart the search
    logic search;   // test one point, advance the index
    logic set_oor;  // mark the current beat out of range
    logic mul;      // form both weighted products
    logic sum;      // add the products and seed the divider
    logic div;      // one restoring division step
    logic emit;     // write the result register
  } plc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // reading lies below the current point's threshold
    logic first;     // current point is point 0
    logic last;      // current point is the last point in use
    logic div_last;  // division step in progress is the final one
  } plc_status_t;

endpackage : plc_pkg

`default_nettype wire

// ===== rtl/core/plc_ctrl.sv =====
// ----------------------------------------------------------------------------
// plc_ctrl: sequencer of the piecewise-linear calibrator
// Steps the datapath through search, multiply, sum and divide, and owns the
// valid/stall handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  input  plc_pkg::plc_status_t status_i,
  output plc_pkg::plc_cmd_t    cmd_o
);
  import plc_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSearch = 3'd1;
  localparam logic [2:0] StMul    = 3'd2;
  localparam logic [2:0] StSum    = 3'd3;
  localparam logic [2:0] StDiv    = 3'd4;
  localparam logic [2:0] StEmit   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSearch;
        end
      end
      StSearch: begin
        cmd_o.search = 1'b1;
        if (status_i.hit) begin
          if (status_i.first) begin
            cmd_o.set_oor = 1'b1;
            state_d       = StEmit;
          end else begin
            state_d = StMul;
          end
        end else if (status_i.last) begin
          cmd_o.set_oor = 1'b1;
          state_d       = StEmit;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div = 1'b1;
        if (status_i.div_last) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        // hold the finished result until the output register frees up
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule : plc_ctrl

`default_nettype wire

// ===== rtl/core/plc_dpath.sv =====
// ----------------------------------------------------------------------------
// plc_dpath: datapath of the piecewise-linear calibrator
// Point registers, serial segment search, weighted products and a
// one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_dpath #(
  parameter int unsigned NUM_POINTS = 8
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [plc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [plc_pkg::CfgW-1:0]      cfg_data_i,
  input  wire  [plc_pkg::DataW-1:0]     raw_value_i,
  input  plc_pkg::plc_cmd_t             cmd_i,
  output plc_pkg::plc_status_t          status_o,
  output logic [plc_pkg::DataW-1:0]     calibrated_value_o,
  output logic                          out_of_range_o
);
  import plc_pkg::*;

  localparam logic [IdxW-1:0]    LastIdx  = IdxW'(NUM_POINTS - 1);
  localparam logic [DivCntW-1:0] LastStep = DivCntW'(DataW - 1);

  logic [CfgW-1:0]      pt_q [NumRegs];
  logic [CfgW-1:0]      prev_q;
  logic [CfgW-1:0]      cur_pt;
  logic [IdxW-1:0]      idx_q;
  logic [DataW-1:0]     raw_q;
  logic [DataW-1:0]     cur_thr, prev_thr;
  logic [DataW-1:0]     w_q, d_q, wmd_q, vlo_q, vhi_q;
  logic [2*DataW-1:0]   p0_q, p1_q;
  logic [2*DataW:0]     sum;
  logic [DataW-1:0]     rem_q, rem_d;
  logic [DataW-1:0]     quo_q;
  logic [DataW:0]       trial, diff;
  logic                 ge;
  logic [DivCntW-1:0]   cnt_q;
  logic                 oor_q;
  logic [DataW-1:0]     cal_q;
  logic                 flag_q;

  // point registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        pt_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumRegs))) begin
      pt_q[cfg_idx_i[IdxW-1:0]] <= cfg_data_i;
    end
  end

  assign cur_pt   = pt_q[idx_q];
  assign cur_thr  = cur_pt[DataW-1:0];
  assign prev_thr = prev_q[DataW-1:0];

  assign status_o.hit      = (raw_q < cur_thr);
  assign status_o.first    = (idx_q == '0);
  assign status_o.last     = (idx_q == LastIdx);
  assign status_o.div_last = (cnt_q == LastStep);

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[DataW-1]};
  assign diff  = trial - {1'b0, w_q};
  assign ge    = (trial >= {1'b0, w_q});
  assign rem_d = ge ? diff[DataW-1:0] : trial[DataW-1:0];

  assign sum = {1'b0, p0_q} + {1'b0, p1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
      oor_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
        oor_q <= 1'b0;
      end else if (cmd_i.search) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.set_oor) begin
        oor_q <= 1'b1;
      end
      if (cmd_i.sum) begin
        cnt_q <= '0;
      end else if (cmd_i.div) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q <= raw_value_i;
    end
    if (cmd_i.search) begin
      // segment runs from the previous point to the current one
      prev_q <= cur_pt;
      w_q    <= cur_thr - prev_thr;
      d_q    <= raw_q - prev_thr;
      wmd_q  <= cur_thr - raw_q;
      vlo_q  <= prev_q[CfgW-1:DataW];
      vhi_q  <= cur_pt[CfgW-1:DataW];
    end
    if (cmd_i.mul) begin
      p0_q <= vlo_q * wmd_q;
      p1_q <= vhi_q * d_q;
    end
    if (cmd_i.sum) begin
      // quotient fits DataW bits, so the upper half is already below w
      rem_q <= sum[2*DataW-1:DataW];
      quo_q <= sum[DataW-1:0];
    end else if (cmd_i.div) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DataW-2:0], ge};
    end
    if (cmd_i.emit) begin
      cal_q  <= oor_q ? OutOfRangeValue : quo_q;
      flag_q <= oor_q;
    end
  end

  assign calibrated_value_o = cal_q;
  assign out_of_range_o     = flag_q;

endmodule : plc_dpath

`default_nettype wire

// ===== rtl/core/piecewise_linear_calibrator_core.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_calibrator_core: piecewise-linear calibration lookup
// Maps a raw 16-bit reading through up to eight calibration points and
// interpolates exactly inside the enclosing segment.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | in_valid_i/in_stall_o  | raw_value_i[15:0]
//  out     | source    | out_valid_o/out_stall_i| calibrated_value_o[15:0],
//          |           |                        | out_of_range_o
//  cfg     | sink      | cfg_we_i               | cfg_idx_i[3:0], cfg_data_i
//
//  An in-range beat runs from accept to result through a serial search of one
//  point per cycle up to the enclosing point, a multiply step, a sum step, 16
//  restoring divider steps and an emit step. Out-of-range beats skip the
//  arithmetic. The next beat is taken in the cycle after emit. Reset clears
//  the point registers and the control state. An output stall holds the
//  result register; a finished result waits in the emit cycle while the
//  earlier one is still held.
//
`default_nettype none

module piecewise_linear_calibrator_core #(
  parameter int unsigned NUM_POINTS = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration
  input  wire                          cfg_we_i,
  input  wire  [plc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [plc_pkg::CfgW-1:0]     cfg_data_i,
  // input beats
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [plc_pkg::DataW-1:0]    raw_value_i,
  // result beats
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [plc_pkg::DataW-1:0]    calibrated_value_o,
  output logic                         out_of_range_o
);
  import plc_pkg::*;

  plc_cmd_t    cmd;
  plc_status_t status;

  // sequencer: handshakes and step order
  plc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // point table, search, products and divider
  plc_dpath #(
    .NUM_POINTS (NUM_POINTS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .raw_value_i        (raw_value_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .calibrated_value_o (calibrated_value_o),
    .out_of_range_o     (out_of_range_o)
  );

endmodule : piecewise_linear_calibrator_core

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the piecewise-linear calibrator core
// Loads calibration tables through the config port, feeds raw readings and
// checks every result beat against an exact interpolation predictor.
// ----------------------------------------------------------------------------
module testbench;

  import plc_pkg::*;

  localparam int unsigned NumPoints  = 8;
  localparam int unsigned DrainCycles = 32;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned RandPhases  = 11;
  localparam int unsigned PhaseBeats  = 115;

  // Register indexes on the config port.
  localparam logic [CfgIdxW-1:0] RegCalPoint0   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegFirstUnused = 4'd8;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             oor;
  } cal_result_t;

  // DUT ports; the inputs are at known values from time zero.
  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               cfg_we_i           = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i          = '0;
  logic [CfgW-1:0]    cfg_data_i         = '0;
  logic               in_valid_i         = 1'b0;
  logic               in_stall_o;
  logic [DataW-1:0]   raw_value_i        = '0;
  logic               out_valid_o;
  logic               out_stall_i        = 1'b0;
  logic [DataW-1:0]   calibrated_value_o;
  logic               out_of_range_o;

  // Predictor copy of the point registers and a staging image for new tables.
  logic [CfgW-1:0]    cal_points [NumRegs];
  logic [CfgW-1:0]    table_img  [NumRegs];
  int                 thr_tmp    [NumRegs];

  logic [DataW-1:0]   pending_raw[$];           // readings not yet put on the bus
  cal_result_t        pending_calibrations[$];  // predicted results, oldest first
  cal_result_t        exp_res;

  int unsigned        queued_cnt   = 0;
  int unsigned        accepted_cnt = 0;
  int unsigned        error_cnt    = 0;
  int unsigned        cycle_cnt    = 0;
  int unsigned        send_gap     = 0;
  int unsigned        stall_left   = 0;
  logic               raw_taken    = 1'b0;
  logic               idle_on      = 1'b0;
  logic               drv_valid;
  logic [DataW-1:0]   drv_raw;

  piecewise_linear_calibrator_core #(
    .NUM_POINTS(NumPoints)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_value_i       (raw_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .calibrated_value_o(calibrated_value_o),
    .out_of_range_o    (out_of_range_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Exact segment interpolation: find the first point above the reading, use
  // the segment ending there, floor((lo*(w-d) + hi*d) / w).
  function automatic cal_result_t calibrate(input logic [DataW-1:0] raw);
    int unsigned      hit;
    int unsigned      i;
    logic [63:0]      thr_lo, thr_hi, span, offset, num;
    cal_result_t      res;
    hit = NumRegs;
    for (i = 0; i < NumPoints; i++) begin
      if (hit == NumRegs && raw < cal_points[i][15:0]) hit = i;
    end
    if (hit == NumRegs || hit == 0) begin
      res.value = OutOfRangeValue;
      res.oor   = 1'b1;
    end else begin
      thr_lo = cal_points[hit-1][15:0];
      thr_hi = cal_points[hit][15:0];
      span   = thr_hi - thr_lo;
      offset = raw - thr_lo;
      num    = cal_points[hit-1][31:16] * (span - offset) + cal_points[hit][31:16] * offset;
      res.value = DataW'(num / span);
      res.oor   = 1'b0;
    end
    return res;
  endfunction

  // Output values lean toward the extremes now and then.
  function automatic logic [15:0] pick_out();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Readings aimed mostly inside the table's segments and at its thresholds.
  function automatic logic [DataW-1:0] pick_raw();
    int unsigned k;
    k = $urandom_range(0, NumPoints - 2);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1:       return cal_points[k][15:0];
      2:       return cal_points[k+1][15:0] - 16'd1;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(cal_points[k+1][15:0], cal_points[k][15:0]));
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx < NumRegs) cal_points[idx[2:0]] = data;
  endtask

  // Write all points, plus one write to an unused index that must be dropped.
  task automatic commit_table();
    int unsigned i;
    for (i = 0; i < NumRegs; i++) write_reg(RegCalPoint0 + i[3:0], table_img[i]);
    write_reg(RegFirstUnused + 4'($urandom_range(0, 7)), $urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_reading(input logic [DataW-1:0] raw);
    pending_raw.push_back(raw);
    queued_cnt++;
  endtask

  // Hold the sender until every queued beat is taken and every result is back,
  // then let the core settle before the config port is touched.
  task automatic drain();
    while (accepted_cnt != queued_cnt || pending_calibrations.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic build_random_table(input int unsigned mode);
    int unsigned i, j, acc, t;
    int          pool [3];
    for (i = 0; i < 3; i++) pool[i] = $urandom_range(0, 65535);
    acc = $urandom_range(0, 65000);
    for (i = 0; i < NumRegs; i++) begin
      case (mode)
        1: begin
          acc = acc + $urandom_range(0, 3);        // tight steps, repeats, w = 1
          thr_tmp[i] = acc;
        end
        2:       thr_tmp[i] = pool[$urandom_range(0, 2)];
        default: thr_tmp[i] = $urandom_range(0, 65535);
      endcase
    end
    // Mode 0 is a well-formed ascending table.
    if (mode == 0) begin
      for (i = 1; i < NumRegs; i++) begin
        t = thr_tmp[i];
        j = i;
        while (j > 0 && thr_tmp[j-1] > t) begin
          thr_tmp[j] = thr_tmp[j-1];
          j--;
        end
        thr_tmp[j] = t;
      end
    end
    for (i = 0; i < NumRegs; i++) table_img[i] = {pick_out(), 16'(thr_tmp[i])};
  endtask

  // Drive side: load the next reading at the falling edge once the current
  // beat is taken; insert sender gaps and receiver stall bursts when enabled.
  always @(negedge clk_i) begin
    drv_valid = in_valid_i && !raw_taken;
    drv_raw   = raw_value_i;
    if (!drv_valid && rst_ni) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_raw.size() > 0) begin
        if (idle_on && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(0, 18);
        end else begin
          drv_valid = 1'b1;
          drv_raw   = pending_raw.pop_front();
        end
      end
    end
    in_valid_i  <= drv_valid;
    raw_value_i <= drv_raw;

    if (!idle_on) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Sample side: predict on every accepted reading, check every result beat.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      raw_taken <= in_valid_i && !in_stall_o;
      if (rst_ni && in_valid_i && !in_stall_o) begin
        pending_calibrations.push_back(calibrate(raw_value_i));
        accepted_cnt++;
      end
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_calibrations.size() == 0) begin
          $error("result beat with no reading pending: value %0d flag %0b",
                 calibrated_value_o, out_of_range_o);
          error_cnt++;
        end else begin
          exp_res = pending_calibrations.pop_front();
          if (calibrated_value_o !== exp_res.value) begin
            $error("calibrated_value: expected %0d, got %0d", exp_res.value,
                   calibrated_value_o);
            error_cnt++;
          end
          if (out_of_range_o !== exp_res.oor) begin
            $error("out_of_range: expected %0b, got %0b", exp_res.oor, out_of_range_o);
            error_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned ph, n;
    for (n = 0; n < NumRegs; n++) cal_points[n] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset table: every threshold is zero, so nothing is ever enclosed.
    queue_reading(16'h0000);
    queue_reading(16'h0001);
    queue_reading(16'h8000);
    queue_reading(16'hFFFF);
    drain();

    // All ones: below point 0, or at the top threshold with nothing above.
    for (n = 0; n < NumRegs; n++) table_img[n] = 32'hFFFF_FFFF;
    commit_table();
    queue_reading(16'h0000);
    queue_reading(16'hFFFE);
    queue_reading(16'hFFFF);
    drain();

    // One full-width falling segment; the zero thresholds above it never hit.
    for (n = 0; n < NumRegs; n++) table_img[n] = '0;
    table_img[0] = {16'hFFFF, 16'h0000};
    table_img[1] = {16'h0000, 16'hFFFF};
    commit_table();
    queue_reading(16'h0000);
    queue_reading(16'h0001);
    queue_reading(16'h7FFF);
    queue_reading(16'hFFFE);
    queue_reading(16'hFFFF);
    drain();

    // Ascending ramp with a unit-width segment and extreme output values.
    table_img[0] = {16'd0,     16'd100};
    table_img[1] = {16'd65535, 16'd1000};
    table_img[2] = {16'd0,     16'd1001};
    table_img[3] = {16'd40000, 16'd5000};
    table_img[4] = {16'd12345, 16'd20000};
    table_img[5] = {16'd40000, 16'd40000};
    table_img[6] = {16'd100,   16'd60000};
    table_img[7] = {16'd65535, 16'd65535};
    commit_table();
    queue_reading(16'd0);
    queue_reading(16'd99);
    queue_reading(16'd100);
    queue_reading(16'd101);
    queue_reading(16'd999);
    queue_reading(16'd1000);
    queue_reading(16'd3000);
    queue_reading(16'd19999);
    queue_reading(16'd30000);
    queue_reading(16'd59999);
    queue_reading(16'd65534);
    queue_reading(16'd65535);
    drain();

    // Random tables; most are ascending, the rest clustered, unsorted or raw.
    // Each table change waits for a full drain; the last phase runs without idling.
    for (ph = 0; ph < RandPhases; ph++) begin
      case (ph % 5)
        1:       build_random_table(1);
        3:       build_random_table(2);
        4:       build_random_table(3);
        default: build_random_table(0);
      endcase
      commit_table();
      idle_on = (ph != RandPhases - 1) && ($urandom_range(0, 3) != 0);
      for (n = 0; n < PhaseBeats; n++) queue_reading(pick_raw());
      drain();
    end

    while (accepted_cnt != queued_cnt || pending_calibrations.size() != 0)
      @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (error_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
